// File: sv/bdpl_pkg.sv
package bdpl_pkg;

   // time and register widths
   localparam int TIME_BITS      = 32;
   localparam int DEBOUNCE_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVE_LOW    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TIME = 2'd1;

   // reset values of the configuration registers
   localparam logic                     ACTIVE_LOW_RESET    = 1'b1;
   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_TIME_RESET = 16'd20;

   // one captured sample
   typedef struct packed {
      logic                 level;
      logic [TIME_BITS-1:0] now;
   } sample_type;

   // one result item
   typedef struct packed {
      logic                 press_event;
      logic [TIME_BITS-1:0] event_time;
      logic                 event_level;
      logic                 stable_pressed;
      logic [TIME_BITS-1:0] last_latency;
      logic [TIME_BITS-1:0] max_latency;
   } result_type;

   // level that counts as pressed under the given polarity
   function automatic logic is_pressed(input logic level, input logic active_low);
      is_pressed = active_low ? ~level : level;
   endfunction

endpackage

// File: sv/button_debounce_press_latency_top.sv
// Button debouncer with press latency measurement.
// req_ channel: one raw pin sample (req_sample_level) with its millisecond
// timestamp (req_now_time) per transfer; a transfer happens when req_valid is
// high and req_stall is low.
// rsp_ channel: exactly one result per sample, in order: press event flag,
// event time and level, debounced pressed status, latest and peak latency.
// csr_ channel: index 0 sets active_low, index 1 sets debounce_time;
// csr_ready is always high, writes are meant only while the block is idle.
// Pipeline: each sample passes the input register, then the result
// register, which loads it once the result register is free or being taken.
// Throughput: one sample per cycle while rsp_stall is low, set by the
// state update between those two registers.
// Reset clears all debouncer state and the valid flags; active_low returns
// to 1 and debounce_time to 20. The first sample after reset only primes.
// When the receiver holds rsp_stall, the result stays put, the input
// register still takes one more sample if it is empty, and then req_stall
// is raised.
module button_debounce_press_latency_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_sample_level,
   input  logic [31:0]                          req_now_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_press_event,
   output logic [31:0]                          rsp_event_time,
   output logic                                 rsp_event_level,
   output logic                                 rsp_stable_pressed,
   output logic [31:0]                          rsp_last_latency,
   output logic [31:0]                          rsp_max_latency,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bdpl_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bdpl_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   bdpl_pkg::sample_type req_sample, sample;
   bdpl_pkg::result_type result;
   logic                 sample_valid;
   logic                 advance;

   assign req_sample.level = req_sample_level;
   assign req_sample.now   = req_now_time;
   assign csr_ready        = 1'b1;

   // input register
   bdpl_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .advance      (advance),
      .sample_valid (sample_valid),
      .sample       (sample)
   );

   // debounce step and result register
   bdpl_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .sample_valid (sample_valid),
      .sample       (sample),
      .rsp_stall    (rsp_stall),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .result       (result)
   );

   // unpack the result
   assign rsp_press_event    = result.press_event;
   assign rsp_event_time     = result.event_time;
   assign rsp_event_level    = result.event_level;
   assign rsp_stable_pressed = result.stable_pressed;
   assign rsp_last_latency   = result.last_latency;
   assign rsp_max_latency    = result.max_latency;

endmodule

// File: sv/bdpl_in_stage.sv
module bdpl_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  bdpl_pkg::sample_type   req_sample,
   input  logic                   advance,
   output logic                   sample_valid,
   output bdpl_pkg::sample_type   sample
);

   logic                 valid_ff, valid_in;
   bdpl_pkg::sample_type sample_ff;
   logic                 load;

   // the stage takes a new transfer when empty or when its item moves on
   assign load      = ~valid_ff | advance;
   assign req_stall = ~load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload captured on every accepted transfer
   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         sample_ff <= req_sample;
      end
   end

   assign sample_valid = valid_ff;
   assign sample       = sample_ff;

endmodule

// File: sv/bdpl_core.sv
module bdpl_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   input  logic [bdpl_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [bdpl_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                  sample_valid,
   input  bdpl_pkg::sample_type                  sample,
   input  logic                                  rsp_stall,
   output logic                                  advance,
   output logic                                  rsp_valid,
   output bdpl_pkg::result_type                  result
);

   localparam int TB = bdpl_pkg::TIME_BITS;
   localparam int DB = bdpl_pkg::DEBOUNCE_BITS;

   // configuration
   logic          active_low_ff;
   logic [DB-1:0] debounce_ff;

   // debouncer state
   logic          primed_ff, primed_in;
   logic          stable_ff, stable_in;
   logic          prev_ff, prev_in;
   logic          armed_ff, armed_in;
   logic          pflag_ff, pflag_in;
   logic [TB-1:0] raw_ff, raw_in;
   logic [TB-1:0] change_ff, change_in;
   logic [TB-1:0] lat_ff, lat_in;
   logic [TB-1:0] peak_ff, peak_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   bdpl_pkg::result_type result_ff, result_in;

   logic          step;
   logic [TB-1:0] held;
   logic          accept_level;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_low_ff <= bdpl_pkg::ACTIVE_LOW_RESET;
         debounce_ff   <= bdpl_pkg::DEBOUNCE_TIME_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            bdpl_pkg::CSR_ACTIVE_LOW:    active_low_ff <= csr_data[0];
            bdpl_pkg::CSR_DEBOUNCE_TIME: debounce_ff   <= csr_data[DB-1:0];
            default: ;
         endcase
      end
   end

   // pipeline moves when the result register is free or being taken
   assign advance = ~rsp_valid_ff | ~rsp_stall;
   assign step    = advance & sample_valid;

   // a raw level change restarts the hold time, so it has held for zero
   assign held         = (sample.level != prev_ff) ? '0 : sample.now - change_ff;
   assign accept_level = (sample.level != stable_ff) && (held >= TB'(debounce_ff));

   // one debounce step for the sample in the input register
   always_comb begin
      primed_in = primed_ff;
      stable_in = stable_ff;
      prev_in   = prev_ff;
      armed_in  = armed_ff;
      pflag_in  = pflag_ff;
      raw_in    = raw_ff;
      change_in = change_ff;
      lat_in    = lat_ff;
      peak_in   = peak_ff;
      result_in = '0;
      if (!primed_ff) begin
         primed_in = 1'b1;
         stable_in = sample.level;
         prev_in   = sample.level;
         change_in = sample.now;
         pflag_in  = bdpl_pkg::is_pressed(sample.level, active_low_ff);
         armed_in  = ~pflag_in;
      end else begin
         // raw level change restarts the hold time
         if (sample.level != prev_ff) begin
            prev_in   = sample.level;
            change_in = sample.now;
            if (bdpl_pkg::is_pressed(sample.level, active_low_ff)) begin
               raw_in = sample.now;
            end
         end
         // held long enough: stable level follows
         if (accept_level) begin
            stable_in = sample.level;
            pflag_in  = bdpl_pkg::is_pressed(sample.level, active_low_ff);
            if (pflag_in && armed_ff &&
                !bdpl_pkg::is_pressed(stable_ff, active_low_ff)) begin
               armed_in = 1'b0;
               lat_in   = (raw_in != '0) ? sample.now - raw_in : '0;
               if (lat_in > peak_ff) begin
                  peak_in = lat_in;
               end
               result_in.press_event = 1'b1;
               result_in.event_time  = (raw_in != '0) ? raw_in : sample.now;
               result_in.event_level = sample.level;
            end else if (!pflag_in) begin
               armed_in = 1'b1;
            end
         end
      end
      result_in.stable_pressed = pflag_in;
      result_in.last_latency   = lat_in;
      result_in.max_latency    = peak_in;
   end

   assign rsp_valid_in = advance ? sample_valid : rsp_valid_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         primed_ff    <= 1'b0;
         stable_ff    <= 1'b0;
         prev_ff      <= 1'b0;
         armed_ff     <= 1'b0;
         pflag_ff     <= 1'b0;
         raw_ff       <= '0;
         change_ff    <= '0;
         lat_ff       <= '0;
         peak_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            primed_ff <= primed_in;
            stable_ff <= stable_in;
            prev_ff   <= prev_in;
            armed_ff  <= armed_in;
            pflag_ff  <= pflag_in;
            raw_ff    <= raw_in;
            change_ff <= change_in;
            lat_ff    <= lat_in;
            peak_ff   <= peak_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

endmodule

// File: dv/testbench.sv
module testbench;

   localparam int TB_TIME_BITS   = bdpl_pkg::TIME_BITS;
   localparam int TB_DB_BITS     = bdpl_pkg::DEBOUNCE_BITS;
   localparam int TB_IDX_BITS    = bdpl_pkg::CSR_INDEX_BITS;
   localparam int TB_DATA_BITS   = bdpl_pkg::CSR_DATA_BITS;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 180;
   localparam int HOLDOFF_AFTER  = 500;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int TAIL_CYCLES    = 8;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type             kind;
      logic                     level;
      logic [TB_TIME_BITS-1:0]  now;
      bdpl_pkg::result_type     res;
      logic [TB_IDX_BITS-1:0]   index;
      logic [TB_DATA_BITS-1:0]  data;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_sample_level = 1'b0;
   logic [31:0]               req_now_time = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_press_event;
   logic [31:0]               rsp_event_time;
   logic                      rsp_event_level;
   logic                      rsp_stable_pressed;
   logic [31:0]               rsp_last_latency;
   logic [31:0]               rsp_max_latency;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [TB_IDX_BITS-1:0]    csr_index = '0;
   logic [TB_DATA_BITS-1:0]   csr_data = '0;

   button_debounce_press_latency_top u_top (.*);

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // configuration copy
   logic                  cfg_active_low = bdpl_pkg::ACTIVE_LOW_RESET;
   logic [TB_DB_BITS-1:0] cfg_debounce   = bdpl_pkg::DEBOUNCE_TIME_RESET;

   // debouncer state copy
   logic                    dbn_primed   = 1'b0;
   logic                    dbn_stable   = 1'b0;
   logic                    dbn_last_raw = 1'b0;
   logic                    dbn_armed    = 1'b0;
   logic                    dbn_pressed  = 1'b0;
   logic [TB_TIME_BITS-1:0] dbn_press_t  = '0;
   logic [TB_TIME_BITS-1:0] dbn_change_t = '0;
   logic [TB_TIME_BITS-1:0] dbn_lat_last = '0;
   logic [TB_TIME_BITS-1:0] dbn_lat_peak = '0;

   bdpl_pkg::result_type expected_q[$];
   stim_row_type         stim_rows[$];

   int fail_count    = 0;
   int results_seen  = 0;
   int events_seen   = 0;
   int samples_sent  = 0;
   int csr_writes    = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles   = 0;

   function automatic logic level_is_pressed(input logic level);
      return cfg_active_low ? (level == 1'b0) : (level == 1'b1);
   endfunction

   // next result of the debouncer for one sample, updating the state copy
   function automatic bdpl_pkg::result_type debounce_predict(
      input logic level, input logic [TB_TIME_BITS-1:0] now);
      bdpl_pkg::result_type    r;
      logic [TB_TIME_BITS-1:0] held;
      logic                    old_stable;
      r = '0;
      if (!dbn_primed) begin
         // first sample only primes
         dbn_primed   = 1'b1;
         dbn_stable   = level;
         dbn_last_raw = level;
         dbn_change_t = now;
         dbn_pressed  = level_is_pressed(level);
         dbn_armed    = !dbn_pressed;
      end else begin
         // raw edge restarts the hold time
         if (level != dbn_last_raw) begin
            dbn_last_raw = level;
            dbn_change_t = now;
            if (level_is_pressed(level))
               dbn_press_t = now;
         end
         held = now - dbn_change_t;
         if (level != dbn_stable && held >= TB_TIME_BITS'(cfg_debounce)) begin
            old_stable  = dbn_stable;
            dbn_stable  = level;
            dbn_pressed = level_is_pressed(level);
            if (dbn_pressed && dbn_armed && !level_is_pressed(old_stable)) begin
               dbn_armed    = 1'b0;
               dbn_lat_last = (dbn_press_t != '0) ? now - dbn_press_t : '0;
               if (dbn_lat_last > dbn_lat_peak)
                  dbn_lat_peak = dbn_lat_last;
               r.press_event = 1'b1;
               r.event_time  = (dbn_press_t != '0) ? dbn_press_t : now;
               r.event_level = level;
            end else if (!dbn_pressed) begin
               dbn_armed = 1'b1;
            end
         end
      end
      r.stable_pressed = dbn_pressed;
      r.last_latency   = dbn_lat_last;
      r.max_latency    = dbn_lat_peak;
      return r;
   endfunction

   function automatic bdpl_pkg::result_type make_result(
      input logic ev, input logic [31:0] ev_t, input logic ev_l, input logic sp,
      input logic [31:0] lat, input logic [31:0] peak);
      bdpl_pkg::result_type r;
      r.press_event    = ev;
      r.event_time     = ev_t;
      r.event_level    = ev_l;
      r.stable_pressed = sp;
      r.last_latency   = lat;
      r.max_latency    = peak;
      return r;
   endfunction

   function automatic void add_sample(input row_kind_type kind, input logic level,
                                      input logic [31:0] now,
                                      input bdpl_pkg::result_type res);
      stim_row_type row;
      row.kind  = kind;
      row.level = level;
      row.now   = now;
      row.res   = res;
      row.index = '0;
      row.data  = '0;
      stim_rows.push_back(row);
   endfunction

   function automatic void add_csr(input logic [TB_IDX_BITS-1:0] index,
                                   input logic [TB_DATA_BITS-1:0] data);
      stim_row_type row;
      row.kind  = ROW_CSR;
      row.level = 1'b0;
      row.now   = '0;
      row.res   = '0;
      row.index = index;
      row.data  = data;
      stim_rows.push_back(row);
   endfunction

   // one sample transfer, with optional idle gap before it
   task automatic send_sample(input logic level, input logic [31:0] now,
                              input logic typed, input bdpl_pkg::result_type typed_res);
      bdpl_pkg::result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_level <= level;
      req_now_time     <= now;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted = debounce_predict(level, now);
      expected_q.push_back(typed ? typed_res : predicted);
      samples_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding result
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [TB_IDX_BITS-1:0] index,
                            input logic [TB_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         bdpl_pkg::CSR_ACTIVE_LOW: begin
            cfg_active_low = data[0];
         end
         bdpl_pkg::CSR_DEBOUNCE_TIME: begin
            cfg_debounce = data[TB_DB_BITS-1:0];
         end
         default: begin
         end
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   // result checker, samples at the rising edge
   always @(posedge clock) begin
      bdpl_pkg::result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_press_event === 1'b1)
            events_seen++;
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected");
            fail_count++;
         end else begin
            exp_r = expected_q.pop_front();
            check_field("press_event", 32'(exp_r.press_event), 32'(rsp_press_event));
            check_field("event_time", exp_r.event_time, rsp_event_time);
            check_field("event_level", 32'(exp_r.event_level), 32'(rsp_event_level));
            check_field("stable_pressed", 32'(exp_r.stable_pressed),
                        32'(rsp_stable_pressed));
            check_field("last_latency", exp_r.last_latency, rsp_last_latency);
            check_field("max_latency", exp_r.max_latency, rsp_max_latency);
         end
      end
   end

   // receiver stalls, with one long hold-off once the run is well under way
   int  holdoff_left = 0;
   logic holdoff_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
         holdoff_done = 1'b1;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      logic                  al_set[PHASE_COUNT];
      logic [TB_DB_BITS-1:0] db_set[PHASE_COUNT];
      logic [TB_DB_BITS-1:0] db;
      logic [31:0]           cur_time;
      logic                  hold_level;
      logic                  level;
      int                    hold_left;
      int                    step_max;

      al_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
      db_set = '{16'd20, 16'd0, 16'hFFFF, 16'd5, 16'd1, 16'd0};

      // directed rows: reset polarity is active low, debounce 20
      // priming sample, then a press whose raw time is zero
      add_sample(ROW_TYPED, 1'b1, 32'd0,
                 make_result(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
      add_sample(ROW_TYPED, 1'b0, 32'd0,
                 make_result(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
      add_sample(ROW_TYPED, 1'b0, 32'd20,
                 make_result(1'b1, 32'd20, 1'b0, 1'b1, 32'd0, 32'd0));
      add_sample(ROW_TYPED, 1'b1, 32'd25,
                 make_result(1'b0, 32'd0, 1'b0, 1'b1, 32'd0, 32'd0));
      add_sample(ROW_TYPED, 1'b1, 32'd45,
                 make_result(1'b0, 32'd0, 1'b0, 1'b0, 32'd0, 32'd0));
      // bouncing press, then accepted
      add_sample(ROW_SAMPLE, 1'b0, 32'd100, '0);
      add_sample(ROW_SAMPLE, 1'b1, 32'd105, '0);
      add_sample(ROW_SAMPLE, 1'b0, 32'd110, '0);
      add_sample(ROW_SAMPLE, 1'b0, 32'd140, '0);
      // release across the time wrap, then the largest latency
      add_sample(ROW_SAMPLE, 1'b1, 32'hFFFF_FFF0, '0);
      add_sample(ROW_SAMPLE, 1'b1, 32'h0000_0010, '0);
      add_sample(ROW_SAMPLE, 1'b0, 32'h0000_0015, '0);
      add_sample(ROW_SAMPLE, 1'b0, 32'hFFFF_FFFF, '0);
      add_sample(ROW_SAMPLE, 1'b1, 32'hFFFF_FFFF, '0);
      add_sample(ROW_SAMPLE, 1'b1, 32'hFFFF_FFFF, '0);
      // polarity flip while held pressed
      add_csr(bdpl_pkg::CSR_ACTIVE_LOW, 16'd0);
      add_sample(ROW_SAMPLE, 1'b1, 32'h0000_0100, '0);
      // zero debounce accepts every edge at once
      add_csr(bdpl_pkg::CSR_DEBOUNCE_TIME, 16'd0);
      add_sample(ROW_SAMPLE, 1'b0, 32'h0000_0200, '0);
      add_sample(ROW_SAMPLE, 1'b1, 32'h0000_0200, '0);
      // longest debounce, one short of it and then exactly it
      add_csr(bdpl_pkg::CSR_DEBOUNCE_TIME, 16'hFFFF);
      add_sample(ROW_SAMPLE, 1'b0, 32'h0000_0300, '0);
      add_sample(ROW_SAMPLE, 1'b0, 32'h0000_0300 + 32'd65534, '0);
      add_sample(ROW_SAMPLE, 1'b0, 32'h0000_0300 + 32'd65535, '0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 17;
      recv_idle_pct = 88;
      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            wait_drain();
            write_csr(stim_rows[i].index, stim_rows[i].data);
         end else begin
            send_sample(stim_rows[i].level, stim_rows[i].now,
                        stim_rows[i].kind == ROW_TYPED, stim_rows[i].res);
         end
      end

      // random phases, one register setting each
      for (int p = 0; p < PHASE_COUNT; p++) begin
         db = (p == PHASE_COUNT - 1) ? TB_DB_BITS'($urandom) : db_set[p];
         wait_drain();
         write_csr(bdpl_pkg::CSR_ACTIVE_LOW, TB_DATA_BITS'(al_set[p]));
         write_csr(bdpl_pkg::CSR_DEBOUNCE_TIME, db);
         step_max   = int'(db) / 3 + 2;
         cur_time   = (p % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom;
         hold_level = 1'($urandom_range(0, 1));
         hold_left  = 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i < PHASE_ITEMS / 3) begin
               send_idle_pct = 17;
               recv_idle_pct = 88;
            end else if (i < 2 * PHASE_ITEMS / 3) begin
               send_idle_pct = 88;
               recv_idle_pct = 17;
            end else begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            // sender pause until the pipe is empty
            if (p == 1 && i == PHASE_ITEMS / 2)
               wait_drain();
            // mostly held levels with bounce, some pure noise
            if (hold_left == 0) begin
               hold_level = ~hold_level;
               hold_left  = int'($urandom_range(1, 10));
            end
            hold_left--;
            level = hold_level;
            if ($urandom_range(0, 99) < 15)
               level = ~level;
            cur_time = cur_time + 32'($urandom_range(0, step_max));
            if ($urandom_range(0, 99) < 8) begin
               cur_time = $urandom;
               level    = 1'($urandom_range(0, 1));
            end
            send_sample(level, cur_time, 1'b0, '0);
         end
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      $display("covered %0d samples, %0d results, %0d press events, %0d register writes",
               samples_sent, results_seen, events_seen, csr_writes);
      $display("both polarities, debounce from 0 to 65535, time wrap and stall pressure");
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
